/* hw/rtl/cpc_pkg.sv */
`timescale 1ns / 1ps

package cpc_pkg;

   // Fixed field widths
   localparam int CODE_W   = 16;
   localparam int FLIP_W   = 5;
   localparam int TOTAL_W  = 32;
   localparam int REQ_W    = 2 * CODE_W;

   // Defaults for the top-level parameters
   localparam int CODE_BITS_DEF   = 16;
   localparam int MAX_SEQ_LEN_DEF = 65536;

   // Sequence tag kept beside each histogram count
   localparam int EPOCH_BITS = 8;

   localparam logic [FLIP_W-1:0] FLIP_RESET = FLIP_W'(16);

   typedef struct packed {
      logic clear;
      logic add;
   } acc_ctl_type;

   typedef struct packed {
      logic we;
      logic re;
   } mem_cmd_type;

endpackage

/* hw/rtl/cpc_hist_mem.sv */
`timescale 1ns / 1ps

module cpc_hist_mem #(
   parameter int ADDR_W = 16,
   parameter int DATA_W = 25
) (
   input  logic                     clock,
   input  cpc_pkg::mem_cmd_type     cmd,
   input  logic [ADDR_W-1:0]        addr,
   input  logic [DATA_W-1:0]        wdata,
   output logic [DATA_W-1:0]        rdata
);
   import cpc_pkg::*;

   localparam int DEPTH = 1 << ADDR_W;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   // single port: write wins, otherwise read into the output register
   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem[addr] <= wdata;
      end else if (cmd.re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/cpc_sat_acc.sv */
`timescale 1ns / 1ps

module cpc_sat_acc #(
   parameter int ADD_W = 17
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cpc_pkg::acc_ctl_type          ctl,
   input  logic [ADD_W-1:0]              add_val,
   output logic [cpc_pkg::TOTAL_W-1:0]   total
);
   import cpc_pkg::*;

   logic [TOTAL_W-1:0] total_ff;
   logic [TOTAL_W-1:0] total_in;
   logic [TOTAL_W:0]   sum;

   // saturating add of one count per step
   assign sum = {1'b0, total_ff} + (TOTAL_W + 1)'(add_val);

   always_comb begin
      total_in = total_ff;
      if (ctl.clear) begin
         total_in = '0;
      end else if (ctl.add) begin
         total_in = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else begin
         total_ff <= total_in;
      end
   end

   assign total = total_ff;

endmodule

/* hw/rtl/causal_onebit_pair_counter_unit.sv */
`timescale 1ns / 1ps

// Channel  Dir  Handshake              Payload
// req      in   req_tvalid/req_tready  tdata: query_code, key_code; tuser: first
// rsp      out  rsp_tvalid/rsp_tready  tdata: pair_total
// csr      in   csr_we                 csr_wdata: flip_bits
//
// Per item, tries = min(flip_bits, CODE_BITS): after the accept step come one histogram
// read per flipped bit, one key read and one key write, all on the single-port
// histogram memory, and then the result step.
// Reset starts a clearing pass over all 2^CODE_BITS entries; the same pass runs on every
// 2^EPOCH_BITS-th first item, when the sequence tag wraps. No item is taken meanwhile.
// A result waits in the output register; the next item is accepted as soon as the
// sequencer is idle, and the final step stalls only if the output is still full.
module causal_onebit_pair_counter_unit #(
   parameter int CODE_BITS   = cpc_pkg::CODE_BITS_DEF,
   parameter int MAX_SEQ_LEN = cpc_pkg::MAX_SEQ_LEN_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [cpc_pkg::REQ_W-1:0]     req_tdata,   // [15:0] query_code, [31:16] key_code
   input  logic                          req_tuser,   // [0] first
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [cpc_pkg::TOTAL_W-1:0]   rsp_tdata,   // [31:0] pair_total
   input  logic                          csr_we,
   input  logic [cpc_pkg::FLIP_W-1:0]    csr_wdata    // [4:0] flip_bits
);
   import cpc_pkg::*;

   localparam int CNT_W  = $clog2(MAX_SEQ_LEN + 1);
   localparam int MEM_W  = EPOCH_BITS + CNT_W;
   localparam int TRY_W  = $clog2(CODE_BITS + 1);
   localparam int EXT_W  = (CODE_BITS > CODE_W) ? CODE_BITS : CODE_W;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_KEY_RD,
      ST_KEY_WR,
      ST_DONE
   } state_type;

   // registers
   state_type              state_ff,   state_in;
   logic [FLIP_W-1:0]      flip_ff,    flip_in;
   logic [CODE_BITS-1:0]   q_ff,       q_in;
   logic [CODE_BITS-1:0]   k_ff,       k_in;
   logic [TRY_W-1:0]       tries_ff,   tries_in;
   logic [TRY_W-1:0]       j_ff,       j_in;
   logic [CODE_BITS-1:0]   clr_ff,     clr_in;
   logic                   resume_ff,  resume_in;
   logic [EPOCH_BITS-1:0]  epoch_ff,   epoch_in;
   logic                   pend_ff,    pend_in;
   logic                   rsp_vld_ff, rsp_vld_in;
   logic [TOTAL_W-1:0]     rsp_dat_ff, rsp_dat_in;

   // datapath
   logic [EXT_W-1:0]       q_ext;
   logic [EXT_W-1:0]       k_ext;
   logic [TRY_W-1:0]       req_tries;
   logic                   accept;
   mem_cmd_type            mem_cmd;
   logic [CODE_BITS-1:0]   mem_addr;
   logic [MEM_W-1:0]       mem_wdata;
   logic [MEM_W-1:0]       mem_rdata;
   logic [CNT_W-1:0]       rd_cnt;
   logic [CNT_W-1:0]       inc_cnt;
   acc_ctl_type            acc_ctl;
   logic [TOTAL_W-1:0]     total;

   // take codes modulo 2^CODE_BITS, zero-padded if the code space is wider
   assign q_ext = EXT_W'(req_tdata[CODE_W-1:0]);
   assign k_ext = EXT_W'(req_tdata[REQ_W-1:CODE_W]);

   // flips beyond the code width name codes no key can hold
   assign req_tries = (32'(flip_ff) > CODE_BITS) ? TRY_W'(CODE_BITS)
                                                 : TRY_W'(flip_ff);

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // an entry tagged with an older sequence reads as zero
   assign rd_cnt  = (mem_rdata[MEM_W-1:CNT_W] == epoch_ff) ? mem_rdata[CNT_W-1:0] : '0;
   assign inc_cnt = (32'(rd_cnt) < MAX_SEQ_LEN) ? rd_cnt + CNT_W'(1) : rd_cnt;

   // memory port
   always_comb begin
      mem_cmd   = '0;
      mem_addr  = k_ff;
      mem_wdata = {epoch_ff, inc_cnt};
      case (state_ff)
         ST_CLEAR: begin
            mem_cmd.we = 1'b1;
            mem_addr   = clr_ff;
            mem_wdata  = '0;
         end
         ST_LOOK: begin
            mem_cmd.re = 1'b1;
            mem_addr   = q_ff ^ (CODE_BITS'(1) << j_ff);
         end
         ST_KEY_RD: begin
            mem_cmd.re = 1'b1;
         end
         ST_KEY_WR: begin
            mem_cmd.we = 1'b1;
         end
         default: begin
            mem_cmd = '0;
         end
      endcase
   end

   // fold each lookup into the total the cycle after its read
   always_comb begin
      acc_ctl.clear = accept && req_tuser;
      acc_ctl.add   = pend_ff;
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      flip_in    = csr_we ? csr_wdata : flip_ff;
      q_in       = q_ff;
      k_in       = k_ff;
      tries_in   = tries_ff;
      j_in       = j_ff;
      clr_in     = clr_ff;
      resume_in  = resume_ff;
      epoch_in   = epoch_ff;
      pend_in    = (state_ff == ST_LOOK);
      rsp_vld_in = rsp_vld_ff && !rsp_tready;
      rsp_dat_in = rsp_dat_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + CODE_BITS'(1);
            if (&clr_ff) begin
               if (!resume_ff) begin
                  state_in = ST_IDLE;
               end else if (tries_ff == '0) begin
                  state_in = ST_KEY_RD;
               end else begin
                  state_in = ST_LOOK;
               end
            end
         end
         ST_IDLE: begin
            if (accept) begin
               q_in     = q_ext[CODE_BITS-1:0];
               k_in     = k_ext[CODE_BITS-1:0];
               tries_in = req_tries;
               j_in     = '0;
               if (req_tuser && (&epoch_ff)) begin
                  // tag space used up: wipe the memory, restart tags
                  epoch_in  = '0;
                  clr_in    = '0;
                  resume_in = 1'b1;
                  state_in  = ST_CLEAR;
               end else begin
                  if (req_tuser) begin
                     epoch_in = epoch_ff + EPOCH_BITS'(1);
                  end
                  state_in = (req_tries == '0) ? ST_KEY_RD : ST_LOOK;
               end
            end
         end
         ST_LOOK: begin
            j_in = j_ff + TRY_W'(1);
            if (j_ff == tries_ff - TRY_W'(1)) begin
               state_in = ST_KEY_RD;
            end
         end
         ST_KEY_RD: begin
            state_in = ST_KEY_WR;
         end
         ST_KEY_WR: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in = 1'b1;
               rsp_dat_in = total;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         flip_ff    <= FLIP_RESET;
         clr_ff     <= '0;
         resume_ff  <= 1'b0;
         epoch_ff   <= '0;
         pend_ff    <= 1'b0;
         rsp_vld_ff <= 1'b0;
         tries_ff   <= '0;
         j_ff       <= '0;
      end else begin
         state_ff   <= state_in;
         flip_ff    <= flip_in;
         clr_ff     <= clr_in;
         resume_ff  <= resume_in;
         epoch_ff   <= epoch_in;
         pend_ff    <= pend_in;
         rsp_vld_ff <= rsp_vld_in;
         tries_ff   <= tries_in;
         j_ff       <= j_in;
      end
      q_ff       <= q_in;
      k_ff       <= k_in;
      rsp_dat_ff <= rsp_dat_in;
   end

   cpc_hist_mem #(
      .ADDR_W (CODE_BITS),
      .DATA_W (MEM_W)
   ) u_hist_mem (
      .clock (clock),
      .cmd   (mem_cmd),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   cpc_sat_acc #(
      .ADD_W (CNT_W)
   ) u_sat_acc (
      .clock   (clock),
      .reset   (reset),
      .ctl     (acc_ctl),
      .add_val (rd_cnt),
      .total   (total)
   );

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_dat_ff;

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

// Tracks the expected running totals: a shadow histogram keyed by code, tagged
// with a sequence number so that a first item clears it in one step.
class pair_count_board;
   int unsigned key_count [2**cpc_pkg::CODE_BITS_DEF];
   int unsigned count_seq [2**cpc_pkg::CODE_BITS_DEF];
   int unsigned seq_id = 1;
   int unsigned flip   = 32'(cpc_pkg::FLIP_RESET);
   bit [31:0]   total;
   bit [31:0]   totals_due [$];
   int unsigned faults;

   function int unsigned count_of(bit [15:0] code);
      return (count_seq[code] == seq_id) ? key_count[code] : 0;
   endfunction

   // Predict the total for one accepted item, then count its key.
   function void take_item(bit [15:0] query, bit [15:0] key, bit first);
      longint unsigned sum;
      int unsigned     tries;
      int unsigned     j;
      int unsigned     hits;
      if (first) begin
         seq_id++;
         total = '0;
      end
      tries = (flip > cpc_pkg::CODE_BITS_DEF) ? cpc_pkg::CODE_BITS_DEF : flip;
      sum = total;
      for (j = 0; j < tries; j++)
         sum += count_of(query ^ (16'd1 << j));
      total = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
      hits = count_of(key);
      if (hits < cpc_pkg::MAX_SEQ_LEN_DEF) begin
         key_count[key] = hits + 1;
         count_seq[key] = seq_id;
      end
      totals_due = {totals_due, total};
   endfunction

   function void check_total(bit [31:0] seen);
      bit [31:0] want;
      if (totals_due.size() == 0) begin
         $display("%0t: unexpected pair_total %0d, none expected", $time, seen);
         faults++;
      end else begin
         want = totals_due.pop_front();
         if (seen !== want) begin
            $display("%0t: pair_total expected %0d, got %0d", $time, want, seen);
            faults++;
         end
      end
   endfunction
endclass

module tb_top;

   logic                         clock      = 1'b0;
   logic                         reset      = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [cpc_pkg::REQ_W-1:0]    req_tdata  = '0;   // [15:0] query_code, [31:16] key_code
   logic                         req_tuser  = 1'b0; // [0] first
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [cpc_pkg::TOTAL_W-1:0]  rsp_tdata;         // [31:0] pair_total
   logic                         csr_we     = 1'b0;
   logic [cpc_pkg::FLIP_W-1:0]   csr_wdata  = '0;   // [4:0] flip_bits

   pair_count_board board = new;

   // Set to suppress all idling on both sides for a stretch.
   bit          quiet;
   int unsigned rsp_hold;

   causal_onebit_pair_counter_unit #(
      .CODE_BITS   (cpc_pkg::CODE_BITS_DEF),
      .MAX_SEQ_LEN (cpc_pkg::MAX_SEQ_LEN_DEF)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Draw the idle cycles ahead of one item on either side.
   function automatic int unsigned draw_wait();
      return quiet ? 0 : $urandom_range(0, 8);
   endfunction

   // Pick a code close to the sequence base most of the time, so that lookups
   // land on counted keys; otherwise take any code.
   function automatic bit [15:0] near_code(bit [15:0] base);
      int unsigned pick;
      pick = $urandom_range(0, 7);
      if (pick < 2)
         return base;
      else if (pick < 5)
         return base ^ (16'd1 << $urandom_range(0, 15));
      else if (pick == 5)
         return base ^ (16'd1 << $urandom_range(0, 15)) ^ (16'd1 << $urandom_range(0, 15));
      else
         return 16'($urandom);
   endfunction

   // Receive side: check every accepted result, then hold tready low for a
   // random number of cycles before taking the next one.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold = 0;
      end else if (rsp_tvalid && rsp_tready) begin
         board.check_total(rsp_tdata);
         rsp_hold = draw_wait();
         if (rsp_hold != 0)
            rsp_tready <= 1'b0;
      end else if (!rsp_tready) begin
         if (rsp_hold > 1) begin
            rsp_hold--;
         end else begin
            rsp_hold = 0;
            rsp_tready <= 1'b1;
         end
      end
   end

   // Offer one item after a random gap and hold it until accepted. Leave
   // tvalid high on return so back-to-back items need no extra step.
   task automatic send_item(input bit [15:0] query, input bit [15:0] key, input bit first);
      int unsigned gap;
      gap = draw_wait();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {key, query};
      req_tuser  <= first;
      do @(posedge clock); while (!req_tready);
      board.take_item(query, key, first);
   endtask

   // Drop tvalid and hold until every expected total has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.totals_due.size() != 0) @(posedge clock);
   endtask

   // Write flip_bits only with nothing in flight.
   task automatic write_flip(input bit [cpc_pkg::FLIP_W-1:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      board.flip = 32'(value);
   endtask

   bit [cpc_pkg::FLIP_W-1:0] flip_plan [12] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd2,
                                                5'd7, 5'd12, 5'd15, 5'd4, 5'd9, 5'd16};

   initial begin
      int unsigned sent;
      int unsigned pause_at;
      int unsigned seq_len;
      int unsigned i;
      int unsigned p;
      bit [15:0]   base;
      bit [15:0]   code;
      bit          first;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part, first with the reset value of flip_bits (all 16 bits):
      // low and high codes, top-bit neighbors, a mid-sequence restart.
      send_item(16'h0000, 16'h0001, 1'b1);
      send_item(16'h0000, 16'h8000, 1'b0);
      send_item(16'h0000, 16'h0000, 1'b0);
      send_item(16'h0001, 16'hFFFF, 1'b0);
      send_item(16'hFFFE, 16'hFFFE, 1'b0);
      send_item(16'hFFFF, 16'h7FFF, 1'b0);
      send_item(16'h7FFF, 16'hFFFF, 1'b1);
      send_item(16'h7FFF, 16'h0000, 1'b0);
      send_item(16'hFFFF, 16'hFFFF, 1'b0);

      // Only bit 0 tried.
      write_flip(5'd1);
      send_item(16'h0000, 16'h0001, 1'b1);
      send_item(16'h0000, 16'h0002, 1'b0);
      send_item(16'h0000, 16'h0003, 1'b0);
      send_item(16'h0002, 16'h0000, 1'b0);

      // No lookups at all: the total must hold.
      write_flip(5'd0);
      send_item(16'h0000, 16'h0001, 1'b0);
      send_item(16'h0001, 16'h0000, 1'b0);
      send_item(16'h0000, 16'h0000, 1'b1);

      // Values beyond the code width clamp to the 16 real bit positions.
      write_flip(5'd31);
      send_item(16'h8000, 16'h0000, 1'b1);
      send_item(16'h0000, 16'h8000, 1'b0);
      send_item(16'h8000, 16'hA5A5, 1'b0);
      write_flip(5'd17);
      send_item(16'h0000, 16'h8000, 1'b0);
      send_item(16'h5A5A, 16'h5A5A, 1'b0);

      // Random part: twelve settings, fifty items each, mostly
      // well-formed sequences around a random base code.
      for (p = 0; p < 12; p++) begin
         write_flip(flip_plan[p]);
         quiet    = ($urandom_range(0, 3) == 0);
         sent     = 0;
         pause_at = $urandom_range(10, 45);
         while (sent < 50) begin
            seq_len = $urandom_range(1, 40);
            base    = 16'($urandom);
            for (i = 0; i < seq_len && sent < 50; i++) begin
               // Occasionally carry a sequence on, or restart one midway.
               first = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0);
               send_item(near_code(base), near_code(base), first);
               sent++;
               // Stall the sender until the block has drained completely.
               if (sent == pause_at)
                  drain();
            end
         end
      end

      // Many short sequences: enough first items to wrap the block's sequence
      // tag, with keys reused across sequences so stale counts would show.
      write_flip(5'd1);
      quiet = 1'b0;
      for (i = 0; i < 300; i++) begin
         code = 16'($urandom_range(0, 7) << 4);
         send_item(code, code ^ 16'h0001, 1'b1);
         send_item(code, 16'($urandom_range(0, 127)), 1'b0);
      end

      // Wait out the last results, plus a tail to catch any stray one.
      drain();
      repeat (40) @(posedge clock);
      if (board.faults == 0)
         $display("causal_onebit_pair_counter_unit test passed");
      else
         $display("causal_onebit_pair_counter_unit test failed");
      $finish;
   end

   // Watchdog: well beyond the slowest correct run.
   initial begin
      #100_000_000;
      $display("causal_onebit_pair_counter_unit test failed");
      $finish;
   end

endmodule
